[hdl/wcs_pkg.sv]
// Shared types, register codes and palette for the waveform column segment block.
package wcs_pkg;

   localparam int MAX_COLUMNS_DEFAULT  = 4096;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int COLUMN_W = 12;
   localparam int ROW_W    = 12;
   localparam int SPAN_W   = 9;
   localparam int PIXEL_W  = 24;
   localparam int HEIGHT_W = 8;
   localparam int DIVISOR_W = 16;

   localparam logic [12:0] WIDTH_RESET   = 13'd1024;
   localparam logic [12:0] HEIGHT_RESET  = 13'd256;
   localparam logic [12:0] HEIGHT_LIMIT  = 13'd4096;
   localparam logic [4:0]  BITS_RESET    = 5'd8;
   localparam logic [4:0]  BITS_LIMIT    = 5'd16;
   localparam logic [7:0]  HEIGHT_SAT    = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CANVAS_WIDTH  = 3'd0,
      CSR_CANVAS_HEIGHT = 3'd1,
      CSR_SAMPLE_FORMAT = 3'd2,
      CSR_VALID_BITS    = 3'd3,
      CSR_COLOR_SELECT  = 3'd4,
      CSR_SCALE_DIVISOR = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_UBYTE  = 2'd0,
      FMT_SBYTE  = 2'd1,
      FMT_USHORT = 2'd2,
      FMT_SSHORT = 2'd3
   } sample_format_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEGMENT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic segment;
      logic emit;
   } wcs_cmd_type;

   // yellow, cyan, green, magenta, red, blue, white, dark yellow
   localparam logic [7:0] PAL_RED   [8] = '{8'd255, 8'd0, 8'd0, 8'd255,
                                            8'd255, 8'd0, 8'd255, 8'd150};
   localparam logic [7:0] PAL_GREEN [8] = '{8'd255, 8'd255, 8'd255, 8'd0,
                                            8'd0, 8'd0, 8'd255, 8'd150};
   localparam logic [7:0] PAL_BLUE  [8] = '{8'd0, 8'd255, 8'd0, 8'd255,
                                            8'd0, 8'd255, 8'd255, 8'd0};

endpackage

[hdl/wcs_if.sv]
// Sample request and segment response channel interfaces.
interface wcs_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] column;
   logic [11:0] top_row;
   logic [8:0]  span_length;
   logic [23:0] pixel_index;
   logic [7:0]  blue;
   logic [7:0]  green;
   logic [7:0]  red;

   modport source (output valid, output column, output top_row, output span_length,
                   output pixel_index, output blue, output green, output red,
                   input ready);
   modport sink   (input valid, input column, input top_row, input span_length,
                   input pixel_index, input blue, input green, input red,
                   output ready);
endinterface

[hdl/wcs_ctrl.sv]
// Sequencer: accepts a sample, runs the serial divider, builds and emits the segment.
module wcs_ctrl #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wcs_pkg::wcs_cmd_type cmd
);
   import wcs_pkg::*;

   localparam int CNT_W = $clog2(SAMPLE_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WIDTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_DIVIDE;
         ST_DIVIDE:  if (count_ff == '0) state_in = ST_SEGMENT;
         ST_SEGMENT: state_in = ST_EMIT;
         ST_EMIT:    if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE:  cmd.div_step = 1'b1;
         ST_SEGMENT: cmd.segment  = 1'b1;
         ST_EMIT:    cmd.emit     = slot_free;
         default:    cmd = '0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) count_in = CNT_LAST;
      else if (cmd.div_step && count_ff != '0) count_in = count_ff - 1'b1;
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/wcs_datapath.sv]
// Registers, sample offset, serial divider, segment geometry and output payload.
module wcs_datapath #(
   parameter int MAX_COLUMNS  = 4096,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [wcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wcs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [SAMPLE_WIDTH-1:0]            sample,
   input  wcs_pkg::wcs_cmd_type               cmd,
   output logic [wcs_pkg::COLUMN_W-1:0]       column,
   output logic [wcs_pkg::ROW_W-1:0]          top_row,
   output logic [wcs_pkg::SPAN_W-1:0]         span_length,
   output logic [wcs_pkg::PIXEL_W-1:0]        pixel_index,
   output logic [7:0]                         blue,
   output logic [7:0]                         green,
   output logic [7:0]                         red
);
   import wcs_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);

   // configuration
   logic [12:0]          width_ff, height_ff;
   sample_format_type    format_ff;
   logic [4:0]           bits_ff;
   logic [2:0]           color_ff;
   logic [DIVISOR_W-1:0] divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         format_ff  <= FMT_UBYTE;
         bits_ff    <= BITS_RESET;
         color_ff   <= 3'd0;
         divisor_ff <= DIVISOR_W'(1);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CANVAS_WIDTH:  width_ff   <= csr_wdata[12:0];
            CSR_CANVAS_HEIGHT: height_ff  <= csr_wdata[12:0];
            CSR_SAMPLE_FORMAT: format_ff  <= sample_format_type'(csr_wdata[1:0]);
            CSR_VALID_BITS:    bits_ff    <= csr_wdata[4:0];
            CSR_COLOR_SELECT:  color_ff   <= csr_wdata[2:0];
            CSR_SCALE_DIVISOR: divisor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective settings
   logic [12:0]          width_base, width_eff, height_eff;
   logic [4:0]           bits_eff;
   logic [DIVISOR_W-1:0] divisor_eff;
   logic                 is_signed, is_byte;
   logic [15:0]          adder;

   always_comb begin
      width_base  = (width_ff == '0) ? 13'd1 : width_ff;
      width_eff   = (32'(width_base) > MAX_COLUMNS) ? 13'(MAX_COLUMNS) : width_base;
      height_eff  = (height_ff > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_ff;
      bits_eff    = (bits_ff > BITS_LIMIT) ? BITS_LIMIT : bits_ff;
      divisor_eff = (divisor_ff == '0) ? DIVISOR_W'(1) : divisor_ff;
      case (format_ff) inside
         FMT_SBYTE, FMT_SSHORT: is_signed = 1'b1;
         default:               is_signed = 1'b0;
      endcase
      case (format_ff) inside
         FMT_UBYTE, FMT_SBYTE: is_byte = 1'b1;
         default:              is_byte = 1'b0;
      endcase
      adder = (is_signed && bits_eff != '0) ? (16'd1 << (bits_eff - 5'd1)) : 16'd0;
   end

   // offset and wrap
   logic [7:0]              byte_sum;
   logic [SAMPLE_WIDTH-1:0] short_sum, dividend;

   assign byte_sum  = sample[7:0] + adder[7:0];
   assign short_sum = SAMPLE_WIDTH'(17'(sample) + 17'(adder));
   assign dividend  = is_byte ? SAMPLE_WIDTH'(byte_sum) : short_sum;

   // restoring divider, one quotient bit a cycle
   logic [SAMPLE_WIDTH-1:0] work_ff, work_in;
   logic [DIVISOR_W-1:0]    rem_ff, rem_in;
   logic [DIVISOR_W:0]      trial;
   logic                    qbit;

   always_comb begin
      trial   = {rem_ff, work_ff[SAMPLE_WIDTH-1]};
      qbit    = trial >= {1'b0, divisor_eff};
      work_in = work_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         work_in = dividend;
         rem_in  = '0;
      end else if (cmd.div_step) begin
         work_in = {work_ff[SAMPLE_WIDTH-2:0], qbit};
         rem_in  = qbit ? DIVISOR_W'(trial - {1'b0, divisor_eff}) : trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   // segment geometry
   logic [HEIGHT_W-1:0] cur, prev, hi, lo;
   logic [COL_W-1:0]    col;
   logic [HEIGHT_W-1:0] prev_ff, cur_ff;
   logic [COL_W-1:0]    count_ff, col_ff;
   logic [ROW_W-1:0]    top_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [12:0]         hi_plus;

   always_comb begin
      cur     = ((work_ff >> 8) != '0) ? HEIGHT_SAT : work_ff[7:0];
      col     = (32'(count_ff) >= 32'(width_eff)) ? '0 : count_ff;
      prev    = (col == '0) ? cur : prev_ff;
      hi      = (cur >= prev) ? cur : prev;
      lo      = (cur >= prev) ? prev : cur;
      hi_plus = 13'(hi) + 13'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.segment) begin
         col_ff  <= col;
         cur_ff  <= cur;
         top_ff  <= (height_eff >= hi_plus) ? ROW_W'(height_eff - hi_plus) : '0;
         span_ff <= SPAN_W'(hi) - SPAN_W'(lo) + SPAN_W'(1);
      end
   end

   // pixel index, payload and trace state
   logic [24:0]      product;
   logic [COL_W-1:0] count_in;

   assign product  = 25'(top_ff) * 25'(width_eff);
   assign count_in = (32'(col_ff) + 32'd1 >= 32'(width_eff)) ? '0 : COL_W'(col_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.emit) begin
         prev_ff  <= cur_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         column      <= COLUMN_W'(col_ff);
         top_row     <= top_ff;
         span_length <= span_ff;
         pixel_index <= PIXEL_W'(product) + PIXEL_W'(col_ff);
         blue        <= PAL_BLUE[color_ff];
         green       <= PAL_GREEN[color_ff];
         red         <= PAL_RED[color_ff];
      end
   end

endmodule

[hdl/waveform_column_segment.sv]
// Top level of the waveform column segment renderer.
//
// One sample enters per display column on req_bus; for each one a single
// vertical segment leaves on rsp_bus, joining the previous trace height to
// the current one in the current column, with its linear pixel index and the
// trace color. Both channels transfer on valid and ready high. The user must
// write registers by csr_write/csr_index/csr_wdata only while idle, unenforced.
//
// Sequence: after the input transfer the restoring divider retires one
// quotient bit a cycle, then the segment geometry is registered, then the
// pixel index is formed into the output register. The block is back in idle
// as the output register is written, so a new sample can transfer even
// while the last result still waits.
//
// Reset (synchronous) restores register defaults, clears the previous
// height and the column counter and empties the output register. If the
// receiver stalls, the result holds, the next segment waits in the emit step
// until the output register is free and further samples wait at the input.
module waveform_column_segment #(
   parameter int MAX_COLUMNS  = wcs_pkg::MAX_COLUMNS_DEFAULT,
   parameter int SAMPLE_WIDTH = wcs_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [wcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   wcs_req_if.sink                         req_bus,
   wcs_rsp_if.source                       rsp_bus
);
   import wcs_pkg::*;

   wcs_cmd_type cmd;

   // sequencer owns both handshakes and the divider count
   wcs_ctrl #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // datapath holds settings, trace state and the result payload
   wcs_datapath #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .sample      (req_bus.sample),
      .cmd         (cmd),
      .column      (rsp_bus.column),
      .top_row     (rsp_bus.top_row),
      .span_length (rsp_bus.span_length),
      .pixel_index (rsp_bus.pixel_index),
      .blue        (rsp_bus.blue),
      .green       (rsp_bus.green),
      .red         (rsp_bus.red)
   );

   // a transfer in always leaves the block busy on the next cycle
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input taken twice in a row");

   // a result is only written into a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("pending result overwritten");

   // every emit shows up as a valid result
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_bus.valid)
      else $error("emitted result not presented");

   // segment length always lies in 1..256
   a_span_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.span_length != 9'd0 && rsp_bus.span_length <= 9'd256))
      else $error("segment length out of range");

endmodule
